@@ rtl/core/pps_pkg.sv @@
`default_nettype none
package pps_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int JOB_W  = 5;
    localparam int TIME_W = 24;

    typedef struct packed {
        logic load;
        logic scan;
        logic calc;
        logic apply;
        logic record;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic have_best;
        logic job_done;
        logic run_over;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/core/pps_ctrl.sv @@
`default_nettype none
module pps_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_last_job,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output pps_pkg::t_cmd    o_cmd,
    input  pps_pkg::t_status i_status
);
    import pps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_APPLY,
        S_REC,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.calc   = (r_state == S_CALC);
        o_cmd.apply  = (r_state == S_APPLY);
        o_cmd.record = (r_state == S_REC);
        o_cmd.clear  = (r_state == S_OUT) && i_out_ready && i_status.run_over;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_last_job) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = i_status.have_best ? S_APPLY : S_SCAN;
            end
            S_APPLY: begin
                n_state = i_status.job_done ? S_REC : S_SCAN;
            end
            S_REC: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = i_status.run_over ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("record valid outside output state");
    a_rescan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && !i_status.job_done) |=> (r_state == S_SCAN))
        else $error("unfinished job did not rescan");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pps_dp.sv @@
`default_nettype none
module pps_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  pps_pkg::t_cmd                     i_cmd,
    output pps_pkg::t_status                  o_status,
    input  wire  [pps_pkg::ARR_W-1:0]         i_arrival_time,
    input  wire  [pps_pkg::BUR_W-1:0]         i_burst_time,
    input  wire  [pps_pkg::PRI_W-1:0]         i_job_priority,
    output logic [pps_pkg::JOB_W-1:0]         o_job_number,
    output logic [pps_pkg::TIME_W-1:0]        o_start_tick,
    output logic [pps_pkg::TIME_W-1:0]        o_completion_tick,
    output logic [pps_pkg::TIME_W-1:0]        o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]        o_waiting,
    output logic [pps_pkg::TIME_W-1:0]        o_response,
    output logic                              o_last_record
);
    import pps_pkg::*;

    logic [ARR_W-1:0]  r_arr   [MAX_PROCESSES];
    logic [BUR_W-1:0]  r_bur   [MAX_PROCESSES];
    logic [BUR_W-1:0]  r_rem   [MAX_PROCESSES];
    logic [PRI_W-1:0]  r_pri   [MAX_PROCESSES];
    logic [TIME_W-1:0] r_start [MAX_PROCESSES];
    logic [MAX_PROCESSES-1:0] r_done;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_finished;
    logic [TIME_W-1:0] r_tick;
    logic [IDX_W-1:0]  r_scan_idx;

    logic              r_have_best;
    logic [IDX_W-1:0]  r_best_idx;
    logic [ARR_W-1:0]  r_best_arr;
    logic [BUR_W-1:0]  r_best_bur;
    logic [BUR_W-1:0]  r_best_rem;
    logic [PRI_W-1:0]  r_best_pri;
    logic [TIME_W-1:0] r_best_start;
    logic              r_have_next;
    logic [ARR_W-1:0]  r_next_arr;
    logic [BUR_W-1:0]  r_run;

    logic [ARR_W-1:0]  scan_arr;
    logic [BUR_W-1:0]  scan_bur;
    logic [BUR_W-1:0]  scan_rem;
    logic [PRI_W-1:0]  scan_pri;
    logic [TIME_W-1:0] scan_start;
    logic              scan_live;
    logic              arrived;
    logic              take_best;
    logic              take_next;
    logic [TIME_W-1:0] gap;
    logic [BUR_W-1:0]  run_len;
    logic [BUR_W-1:0]  rem_new;
    logic [BUR_W-1:0]  load_bur;
    logic [IDX_W-1:0]  load_idx;

    assign scan_arr   = r_arr[r_scan_idx];
    assign scan_bur   = r_bur[r_scan_idx];
    assign scan_rem   = r_rem[r_scan_idx];
    assign scan_pri   = r_pri[r_scan_idx];
    assign scan_start = (scan_rem == scan_bur) ? r_tick : r_start[r_scan_idx];
    assign scan_live  = !r_done[r_scan_idx];
    assign arrived    = (TIME_W'(scan_arr) <= r_tick);

    assign take_best = scan_live && arrived &&
                       (!r_have_best || (scan_pri > r_best_pri) ||
                        ((scan_pri == r_best_pri) && (scan_arr < r_best_arr)));
    assign take_next = scan_live && !arrived && (!r_have_next || (scan_arr < r_next_arr));

    assign gap     = TIME_W'(r_next_arr) - r_tick;
    assign run_len = (r_have_next && (gap < TIME_W'(r_best_rem))) ? gap[BUR_W-1:0]
                                                                  : r_best_rem;
    assign rem_new = r_best_rem - r_run;

    assign load_bur = (i_burst_time == '0) ? BUR_W'(1) : i_burst_time;
    assign load_idx = r_count[IDX_W-1:0];

    assign o_status.scan_last = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_count);
    assign o_status.have_best = r_have_best;
    assign o_status.job_done  = (rem_new == '0);
    assign o_status.run_over  = (r_finished == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_finished  <= '0;
            r_tick      <= '0;
            r_done      <= '0;
            r_scan_idx  <= '0;
            r_have_best <= 1'b0;
            r_have_next <= 1'b0;
        end else begin
            if (i_cmd.load && (r_count < CNT_W'(MAX_PROCESSES))) begin
                r_arr[load_idx]  <= i_arrival_time;
                r_bur[load_idx]  <= load_bur;
                r_rem[load_idx]  <= load_bur;
                r_pri[load_idx]  <= i_job_priority;
                r_done[load_idx] <= 1'b0;
                r_count          <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
                if (take_best) begin
                    r_have_best  <= 1'b1;
                    r_best_idx   <= r_scan_idx;
                    r_best_arr   <= scan_arr;
                    r_best_bur   <= scan_bur;
                    r_best_rem   <= scan_rem;
                    r_best_pri   <= scan_pri;
                    r_best_start <= scan_start;
                end
                if (take_next) begin
                    r_have_next <= 1'b1;
                    r_next_arr  <= scan_arr;
                end
            end
            if (i_cmd.calc) begin
                r_scan_idx  <= '0;
                r_have_best <= 1'b0;
                r_have_next <= 1'b0;
                if (r_have_best) begin
                    r_run <= run_len;
                end else begin
                    r_tick <= TIME_W'(r_next_arr);
                end
            end
            if (i_cmd.apply) begin
                r_rem[r_best_idx]   <= rem_new;
                r_start[r_best_idx] <= r_best_start;
                r_best_rem          <= rem_new;
                r_tick              <= r_tick + TIME_W'(r_run);
                if (rem_new == '0) begin
                    r_done[r_best_idx] <= 1'b1;
                    r_finished         <= r_finished + CNT_W'(1);
                end
            end
            if (i_cmd.clear) begin
                r_count    <= '0;
                r_finished <= '0;
                r_tick     <= '0;
                r_done     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            o_job_number      <= JOB_W'(r_best_idx) + JOB_W'(1);
            o_start_tick      <= r_best_start;
            o_completion_tick <= r_tick;
            o_turnaround      <= r_tick - TIME_W'(r_best_arr);
            o_waiting         <= r_tick - TIME_W'(r_best_arr) - TIME_W'(r_best_bur);
            o_response        <= r_best_start - TIME_W'(r_best_arr);
            o_last_record     <= (r_finished == r_count);
        end
    end

`ifndef SYNTHESIS
    a_apply_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> !r_done[r_best_idx])
        else $error("finished job selected to run");
    a_idle_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.calc && !r_have_best) |-> r_have_next)
        else $error("idle step with no pending arrival");
    a_fin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished <= r_count)
        else $error("more jobs finished than loaded");
`endif

endmodule
`default_nettype wire

@@ rtl/core/preemptive_priority_scheduler_top.sv @@
// loading: one job request per cycle, no record for a non-final request
// run: each step scans all jobs, then selects and, if a job has arrived, updates it
// a finishing step also forms the record, then waits for the output handshake
// at most 2*job_count steps per run; output handshake stalls add to the run
// reset clears job count, done flags, tick and state; the job stores hold no reset
`default_nettype none
module preemptive_priority_scheduler_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire  [pps_pkg::ARR_W-1:0]   i_arrival_time,
    input  wire  [pps_pkg::BUR_W-1:0]   i_burst_time,
    input  wire  [pps_pkg::PRI_W-1:0]   i_job_priority,
    input  wire                         i_last_job,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [pps_pkg::JOB_W-1:0]   o_job_number,
    output logic [pps_pkg::TIME_W-1:0]  o_start_tick,
    output logic [pps_pkg::TIME_W-1:0]  o_completion_tick,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]  o_waiting,
    output logic [pps_pkg::TIME_W-1:0]  o_response,
    output logic                        o_last_record
);
    import pps_pkg::*;

    t_cmd    cmd;
    t_status status;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_last_job  (i_last_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    pps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_arrival_time    (i_arrival_time),
        .i_burst_time      (i_burst_time),
        .i_job_priority    (i_job_priority),
        .o_job_number      (o_job_number),
        .o_start_tick      (o_start_tick),
        .o_completion_tick (o_completion_tick),
        .o_turnaround      (o_turnaround),
        .o_waiting         (o_waiting),
        .o_response        (o_response),
        .o_last_record     (o_last_record)
    );

endmodule
`default_nettype wire
